FILE: sv/interval_neighbour_distances_core_defines.svh
// assertion macros shared by the interval neighbour distance rtl
`ifndef INTERVAL_NEIGHBOUR_DISTANCES_CORE_DEFINES_SVH
`define INTERVAL_NEIGHBOUR_DISTANCES_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IND_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IND_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ind_pkg.sv
// types, constants and helper functions of the interval neighbour distance block
package ind_pkg;

    // store geometry
    localparam int STORE_DEPTH     = 4096;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int CNT_W           = $clog2(STORE_DEPTH + 1);

    // window geometry
    localparam int MAX_HALF_WINDOW = 31;
    localparam int HW_W            = 5;
    localparam int BIDX_W          = (MAX_HALF_WINDOW > 1) ? $clog2(MAX_HALF_WINDOW) : 1;
    localparam int STEP_W          = $clog2(MAX_HALF_WINDOW + 2);

    // field widths
    localparam int CHROM_W         = 5;
    localparam int POS_W           = 31;
    localparam int DIST_W          = 32;
    localparam int SLOT_W          = 6;
    localparam int ERR_W           = 2;
    localparam int SUM_W           = 38;

    // request codes
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL       = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_LOADED = 2'd2;

    // reset value of the half window register
    localparam logic [HW_W-1:0] HALF_WINDOW_RST = 5'd2;

    // input beat
    typedef struct packed {
        logic               req_type;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
        logic [ADDR_W-1:0]  query_index;
    } in_t;

    // result beat
    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [DIST_W-1:0] distance;
        logic                     last_of_run;
        logic [ERR_W-1:0]         error_code;
    } out_t;

    // one stored interval
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
    } entry_t;

    // one walk step result held for emission
    typedef struct packed {
        logic                    ok;
        logic signed [SUM_W-1:0] sum;
    } step_t;

    // truncated centre of an interval
    function automatic logic [POS_W-1:0] centre_of(input logic [POS_W-1:0] s,
                                                   input logic [POS_W-1:0] e);
        logic [POS_W:0] total;
        total = {1'b0, s} + {1'b0, e};
        return total[POS_W:1];
    endfunction

    // clamp a running sum to the signed distance range
    function automatic logic signed [DIST_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
        lo = {{(SUM_W-DIST_W+1){1'b1}}, {(DIST_W-1){1'b0}}};
        if (v > hi) begin
            return {1'b0, {(DIST_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DIST_W-1){1'b0}}};
        end
        return v[DIST_W-1:0];
    endfunction

endpackage

FILE: sv/ind_ram.sv
// generic single write port, single read port ram with registered read
module ind_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/interval_neighbour_distances_core.sv
// interval neighbour distances: interval store, walk sequencer and result emitter
// append or rejected query: one result beat, registered from the single state once the output register is free
// query: each side reads the centre entry and then walks its n reachable neighbours,
// then 2*half_window + 1 result beats at one per cycle while the output does not stall;
// the walk is bound by the single read port
// synchronous active-low reset empties the store (count zero) and sets half_window to 2
`include "interval_neighbour_distances_core_defines.svh"

module interval_neighbour_distances_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ind_pkg::HW_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ind_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ind_pkg::out_t                 m_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam int ENTRY_W = $bits(ind_pkg::entry_t);

    // control state
    logic [1:0]                    state_reg;
    logic [ind_pkg::HW_W-1:0]      half_window_reg;
    logic [ind_pkg::CNT_W-1:0]     count_reg;
    logic [ind_pkg::ERR_W-1:0]     err_reg;

    // query context
    logic [ind_pkg::ADDR_W-1:0]    centre_idx_reg;
    logic [ind_pkg::HW_W-1:0]      hw_eff_reg;
    logic [ind_pkg::HW_W-1:0]      up_avail_reg;
    logic [ind_pkg::HW_W-1:0]      dn_avail_reg;
    logic                          dir_up_reg;

    // read issue
    logic [ind_pkg::ADDR_W-1:0]    rd_addr_reg;
    logic [ind_pkg::STEP_W-1:0]    rd_left_reg;
    logic                          rd_first_reg;
    logic                          q_valid_reg;
    logic                          q_first_reg;

    // compare stage
    ind_pkg::entry_t               prev_reg;
    logic [ind_pkg::POS_W-1:0]     prev_centre_reg;
    logic                          e_valid_reg;
    logic                          e_ok_reg;
    logic signed [ind_pkg::DIST_W-1:0] e_diff_reg;

    // accumulate stage
    logic signed [ind_pkg::SUM_W-1:0]  sum_reg;
    logic [ind_pkg::BIDX_W-1:0]    wr_k_reg;
    ind_pkg::step_t                up_buf_reg [ind_pkg::MAX_HALF_WINDOW];
    ind_pkg::step_t                dn_buf_reg [ind_pkg::MAX_HALF_WINDOW];

    // emitter
    logic [ind_pkg::SLOT_W-1:0]    e_slot_reg;
    logic                          m_valid_reg;
    ind_pkg::out_t                 m_data_reg;

    // store ram
    logic                          ram_wr_en;
    logic                          ram_rd_en;
    logic [ENTRY_W-1:0]            ram_rd_data;
    ind_pkg::entry_t               nb;
    ind_pkg::entry_t               new_entry;

    logic                          s_fire;
    logic                          out_free;
    logic                          out_load;
    logic                          side_done;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && ((state_reg == ST_SINGLE) || (state_reg == ST_EMIT));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // store write on an accepted append with room left
    assign ram_wr_en = s_fire && (s_data.req_type == ind_pkg::REQ_APPEND)
                       && (count_reg < ind_pkg::CNT_W'(ind_pkg::STORE_DEPTH));
    assign new_entry.chrom     = s_data.chrom;
    assign new_entry.start_pos = s_data.start_pos;
    assign new_entry.end_pos   = s_data.end_pos;
    assign ram_rd_en = (state_reg == ST_WALK) && (rd_left_reg != '0);

    ind_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ind_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ind_pkg::ADDR_W-1:0]),
        .wr_data (new_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // query setup from the incoming beat
    logic                          q_loaded;
    logic [ind_pkg::HW_W-1:0]      hw_clamp;
    logic [ind_pkg::HW_W-1:0]      up_av;
    logic [ind_pkg::HW_W-1:0]      dn_av;
    logic [ind_pkg::CNT_W-1:0]     dn_room;

    always_comb begin
        q_loaded = {1'b0, s_data.query_index} < count_reg;
        if (half_window_reg > ind_pkg::HW_W'(ind_pkg::MAX_HALF_WINDOW)) begin
            hw_clamp = ind_pkg::HW_W'(ind_pkg::MAX_HALF_WINDOW);
        end else begin
            hw_clamp = half_window_reg;
        end
        if (s_data.query_index < ind_pkg::ADDR_W'(hw_clamp)) begin
            up_av = s_data.query_index[ind_pkg::HW_W-1:0];
        end else begin
            up_av = hw_clamp;
        end
        dn_room = count_reg - ind_pkg::CNT_W'(1) - {1'b0, s_data.query_index};
        if (dn_room < ind_pkg::CNT_W'(hw_clamp)) begin
            dn_av = dn_room[ind_pkg::HW_W-1:0];
        end else begin
            dn_av = hw_clamp;
        end
    end

    // neighbour compare: chromosome match, no overlap, centre step
    logic [ind_pkg::POS_W-1:0]         nb_centre;
    logic                              link_ok;
    logic signed [ind_pkg::DIST_W-1:0] link_diff;

    always_comb begin
        nb        = ind_pkg::entry_t'(ram_rd_data);
        nb_centre = ind_pkg::centre_of(nb.start_pos, nb.end_pos);
        if (dir_up_reg) begin
            link_ok   = (nb.chrom == prev_reg.chrom) && !(nb.end_pos > prev_reg.start_pos);
            link_diff = $signed({1'b0, prev_centre_reg}) - $signed({1'b0, nb_centre});
        end else begin
            link_ok   = (nb.chrom == prev_reg.chrom) && !(nb.start_pos < prev_reg.end_pos);
            link_diff = $signed({1'b0, nb_centre}) - $signed({1'b0, prev_centre_reg});
        end
    end

    // running sum with the registered step added
    logic signed [ind_pkg::SUM_W-1:0] sum_add;
    assign sum_add = sum_reg + {{(ind_pkg::SUM_W-ind_pkg::DIST_W){e_diff_reg[ind_pkg::DIST_W-1]}},
                                e_diff_reg};

    assign side_done = (rd_left_reg == '0) && !q_valid_reg && !e_valid_reg;

    // value of the slot being emitted
    logic [ind_pkg::SLOT_W-1:0]        hw_slot;
    logic [ind_pkg::SLOT_W-1:0]        step_k;
    ind_pkg::step_t                    pick;
    logic                              pick_ok;
    logic signed [ind_pkg::DIST_W-1:0] slot_dist;
    logic                              slot_last;

    always_comb begin
        hw_slot   = {{(ind_pkg::SLOT_W-ind_pkg::HW_W){1'b0}}, hw_eff_reg};
        step_k    = '0;
        pick      = '0;
        pick_ok   = 1'b0;
        slot_dist = '0;
        if (e_slot_reg < hw_slot) begin
            step_k  = hw_slot - ind_pkg::SLOT_W'(1) - e_slot_reg;
            pick    = up_buf_reg[step_k[ind_pkg::BIDX_W-1:0]];
            pick_ok = step_k < {{(ind_pkg::SLOT_W-ind_pkg::HW_W){1'b0}}, up_avail_reg};
            slot_dist = (pick_ok && pick.ok) ? ind_pkg::saturate(pick.sum) : '1;
        end else if (e_slot_reg > hw_slot) begin
            step_k  = e_slot_reg - hw_slot - ind_pkg::SLOT_W'(1);
            pick    = dn_buf_reg[step_k[ind_pkg::BIDX_W-1:0]];
            pick_ok = step_k < {{(ind_pkg::SLOT_W-ind_pkg::HW_W){1'b0}}, dn_avail_reg};
            slot_dist = (pick_ok && pick.ok) ? ind_pkg::saturate(pick.sum) : '1;
        end
        slot_last = (e_slot_reg == {hw_slot[ind_pkg::SLOT_W-2:0], 1'b0});
    end

    // configuration register and store count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg <= ind_pkg::HALF_WINDOW_RST;
            count_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                half_window_reg <= cfg_wr_data;
            end
            if (ram_wr_en) begin
                count_reg <= count_reg + ind_pkg::CNT_W'(1);
            end
        end
    end

    // sequencer and walk pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_left_reg  <= '0;
            rd_first_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
            q_first_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
            wr_k_reg     <= '0;
            dir_up_reg   <= 1'b1;
            e_slot_reg   <= '0;
            err_reg      <= ind_pkg::ERR_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            // output register loads a new beat or drains
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // read pipeline stages
            q_valid_reg <= ram_rd_en;
            q_first_reg <= ram_rd_en && rd_first_reg;
            e_valid_reg <= q_valid_reg && !q_first_reg;
            if (ram_rd_en) begin
                rd_left_reg  <= rd_left_reg - ind_pkg::STEP_W'(1);
                rd_first_reg <= 1'b0;
            end
            if (e_valid_reg) begin
                wr_k_reg <= wr_k_reg + ind_pkg::BIDX_W'(1);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.req_type == ind_pkg::REQ_APPEND) begin
                            err_reg   <= ram_wr_en ? ind_pkg::ERR_OK : ind_pkg::ERR_FULL;
                            state_reg <= ST_SINGLE;
                        end else if (!q_loaded) begin
                            err_reg   <= ind_pkg::ERR_NOT_LOADED;
                            state_reg <= ST_SINGLE;
                        end else begin
                            dir_up_reg   <= 1'b1;
                            rd_left_reg  <= ind_pkg::STEP_W'(up_av) + ind_pkg::STEP_W'(1);
                            rd_first_reg <= 1'b1;
                            wr_k_reg     <= '0;
                            state_reg    <= ST_WALK;
                        end
                    end
                end
                ST_SINGLE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    if (side_done) begin
                        if (dir_up_reg) begin
                            dir_up_reg   <= 1'b0;
                            rd_left_reg  <= ind_pkg::STEP_W'(dn_avail_reg) + ind_pkg::STEP_W'(1);
                            rd_first_reg <= 1'b1;
                            wr_k_reg     <= '0;
                        end else begin
                            e_slot_reg <= '0;
                            state_reg  <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        e_slot_reg <= e_slot_reg + ind_pkg::SLOT_W'(1);
                        if (slot_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // query context, read address and datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            centre_idx_reg <= s_data.query_index;
            hw_eff_reg     <= hw_clamp;
            up_avail_reg   <= up_av;
            dn_avail_reg   <= dn_av;
            rd_addr_reg    <= s_data.query_index;
        end else if ((state_reg == ST_WALK) && side_done) begin
            rd_addr_reg <= centre_idx_reg;
        end else if (ram_rd_en) begin
            rd_addr_reg <= dir_up_reg ? rd_addr_reg - ind_pkg::ADDR_W'(1)
                                      : rd_addr_reg + ind_pkg::ADDR_W'(1);
        end

        // compare stage: neighbour becomes the current entry
        if (q_valid_reg) begin
            prev_reg        <= nb;
            prev_centre_reg <= nb_centre;
            e_ok_reg        <= link_ok;
            e_diff_reg      <= link_diff;
        end

        // accumulate stage: record the step for its side
        if ((state_reg == ST_WALK) && side_done) begin
            sum_reg <= '0;
        end else if (s_fire) begin
            sum_reg <= '0;
        end else if (e_valid_reg) begin
            if (e_ok_reg) begin
                sum_reg <= sum_add;
            end
            if (dir_up_reg) begin
                up_buf_reg[wr_k_reg] <= '{ok: e_ok_reg, sum: sum_add};
            end else begin
                dn_buf_reg[wr_k_reg] <= '{ok: e_ok_reg, sum: sum_add};
            end
        end

        // result beat
        if ((state_reg == ST_SINGLE) && out_free) begin
            m_data_reg.slot        <= '0;
            m_data_reg.distance    <= '0;
            m_data_reg.last_of_run <= 1'b1;
            m_data_reg.error_code  <= err_reg;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            m_data_reg.slot        <= e_slot_reg;
            m_data_reg.distance    <= slot_dist;
            m_data_reg.last_of_run <= slot_last;
            m_data_reg.error_code  <= ind_pkg::ERR_OK;
        end
    end

    // the read pipeline is empty whenever a new beat can be taken
    `IND_ASSERT_NOW(a_idle_pipe_empty, aclk, aresetn, state_reg == ST_IDLE,
        !q_valid_reg && !e_valid_reg && (rd_left_reg == '0), "walk pipeline busy while idle")

    // a step is recorded only inside the side's reachable range
    `IND_ASSERT_NOW(a_step_in_range, aclk, aresetn, e_valid_reg,
        {1'b0, wr_k_reg} < (dir_up_reg ? {1'b0, up_avail_reg} : {1'b0, dn_avail_reg}),
        "walk step beyond reachable neighbours")

    // a stored append grows the count by exactly one
    `IND_ASSERT_NEXT(a_append_count, aclk, aresetn, ram_wr_en,
        count_reg == $past(count_reg) + ind_pkg::CNT_W'(1), "store count did not advance")

endmodule
